### hw/rtl/bpc_pkg.sv
// Package for the button press classifier: sizes, item codes, register map
// and the packed per-button state word kept in the state RAM.
// No dependencies.
package bpc_pkg;

  localparam int unsigned BUTTONS = 2;
  localparam int unsigned BTN_W   = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned RAW_W     = 2;
  localparam int unsigned EVT_W     = 2;
  localparam int unsigned EDGE_W    = 1;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  localparam logic [CNT_W-1:0] LATCH_MAX = 8'd255;

  localparam logic [OP_W-1:0] OP_POLL  = 2'd0;
  localparam logic [OP_W-1:0] OP_EDGE  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [APB_AW-1:0] ADDR_DEBOUNCE = 3'd0;
  localparam logic [APB_AW-1:0] ADDR_LONG     = 3'd4;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd30;
  localparam logic [CFG_W-1:0] LONG_RST     = 16'd600;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_time;
    logic [CFG_W-1:0] long_press_time;
  } cfg_t;

  typedef struct packed {
    logic              stable_level;
    logic              last_raw;
    logic              long_done;
    logic [TIME_W-1:0] change_time;
    logic [TIME_W-1:0] press_time;
    logic [CNT_W-1:0]  latch_count;
    logic [TIME_W-1:0] latch_time;
  } entry_t;

  localparam int unsigned ENT_W = $bits(entry_t);

  typedef struct packed {
    logic [BUTTONS-1:0] short_flags;
    logic [BUTTONS-1:0] long_flags;
  } res_t;

endpackage

### hw/rtl/bpc_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module bpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/bpc_seq.sv
// Per-item sequencer: read-modify-write of each button's state word in the
// state RAM, plus the event flag registers. Depends on bpc_pkg, bpc_ram.
module bpc_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bpc_pkg::cfg_t               cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [bpc_pkg::OP_W-1:0]    op_i,
  input  logic [bpc_pkg::TIME_W-1:0]  now_i,
  input  logic [bpc_pkg::RAW_W-1:0]   raw_i,
  input  logic [bpc_pkg::EDGE_W-1:0]  btn_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output bpc_pkg::res_t               res_o
);
  import bpc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_A,
    S_B,
    S_CLR,
    S_FIN
  } state_e;

  state_e             state_q;
  logic [OP_W-1:0]    op_q;
  logic [TIME_W-1:0]  now_q;
  logic [BUTTONS-1:0] raw_q;
  logic [BTN_W-1:0]   idx_q;
  logic [BUTTONS-1:0] vld_q;
  logic [BUTTONS-1:0] short_q;
  logic [BUTTONS-1:0] long_q;
  entry_t             ent_q;
  logic               sh_q;

  logic               last_idx;
  logic               raw_b;
  logic [ENT_W-1:0]   rdata;
  entry_t             rd_ent;
  entry_t             a_d;
  logic               sh_d;
  entry_t             b_d;
  logic               sh_b;
  logic               lg_b;
  entry_t             edge_d;
  entry_t             clr_d;
  logic               we;
  entry_t             wdata;
  logic [TIME_W-1:0]  deb_diff;
  logic [TIME_W-1:0]  long_diff;
  logic [TIME_W-1:0]  latch_diff;

  assign last_idx = (idx_q == BTN_W'(BUTTONS - 1));
  assign raw_b    = raw_q[idx_q];
  assign rd_ent   = vld_q[idx_q] ? entry_t'(rdata) : '0;

  // Poll, first half: raw edge tracking and debounce.
  always_comb begin
    a_d  = rd_ent;
    sh_d = 1'b0;
    if (raw_b != rd_ent.last_raw) begin
      a_d.last_raw    = raw_b;
      a_d.change_time = now_q;
    end
    deb_diff = now_q - a_d.change_time;
    if ((deb_diff >= TIME_W'(cfg_i.debounce_time)) && (raw_b != rd_ent.stable_level)) begin
      a_d.stable_level = raw_b;
      if (raw_b) begin
        a_d.press_time = now_q;
        a_d.long_done  = 1'b0;
        if (rd_ent.latch_count != '0) begin
          a_d.latch_count = rd_ent.latch_count - CNT_W'(1);
        end
      end else begin
        a_d.latch_count = '0;
        sh_d            = !rd_ent.long_done;
      end
    end
  end

  // Poll, second half: long press and latch replay.
  always_comb begin
    b_d       = ent_q;
    sh_b      = sh_q;
    lg_b      = 1'b0;
    long_diff = now_q - ent_q.press_time;
    if (ent_q.stable_level && !ent_q.long_done &&
        (long_diff >= TIME_W'(cfg_i.long_press_time))) begin
      b_d.long_done = 1'b1;
      lg_b          = 1'b1;
    end
    if ((ent_q.latch_count != '0) && !ent_q.stable_level && !raw_b) begin
      b_d.latch_count = ent_q.latch_count - CNT_W'(1);
      sh_b            = 1'b1;
    end
  end

  always_comb begin
    edge_d     = rd_ent;
    latch_diff = now_q - rd_ent.latch_time;
    if (latch_diff >= TIME_W'(cfg_i.debounce_time)) begin
      if (rd_ent.latch_count != LATCH_MAX) begin
        edge_d.latch_count = rd_ent.latch_count + CNT_W'(1);
      end
      edge_d.latch_time = now_q;
    end
  end

  always_comb begin
    clr_d             = '0;
    clr_d.change_time = now_q;
    clr_d.latch_time  = now_q;
  end

  always_comb begin
    we    = 1'b0;
    wdata = b_d;
    unique case (state_q)
      S_B:   we = 1'b1;
      S_A: begin
        we    = (op_q == OP_EDGE);
        wdata = edge_d;
      end
      S_CLR: begin
        we    = 1'b1;
        wdata = clr_d;
      end
      default: we = 1'b0;
    endcase
  end

  bpc_ram #(
    .WIDTH(ENT_W),
    .DEPTH(BUTTONS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(idx_q),
    .wdata_i(wdata),
    .re_i   (state_q == S_RD),
    .raddr_i(idx_q),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_POLL;
      now_q   <= '0;
      raw_q   <= '0;
      idx_q   <= '0;
      vld_q   <= '0;
      short_q <= '0;
      long_q  <= '0;
      ent_q   <= '0;
      sh_q    <= 1'b0;
    end else begin
      if (we) begin
        vld_q[idx_q] <= 1'b1;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q  <= op_i;
            now_q <= now_i;
            raw_q <= BUTTONS'(raw_i);
            idx_q <= '0;
            unique case (op_i)
              OP_POLL:  state_q <= S_RD;
              OP_CLEAR: state_q <= S_CLR;
              OP_EDGE: begin
                idx_q <= BTN_W'(btn_i);
                if (32'(btn_i) < 32'(BUTTONS)) begin
                  state_q <= S_RD;
                end else begin
                  state_q <= S_FIN;
                end
              end
              default: state_q <= S_FIN;
            endcase
          end
        end
        S_RD: state_q <= S_A;
        S_A: begin
          if (op_q == OP_EDGE) begin
            state_q <= S_FIN;
          end else begin
            ent_q   <= a_d;
            sh_q    <= sh_d;
            state_q <= S_B;
          end
        end
        S_B: begin
          short_q[idx_q] <= sh_b;
          long_q[idx_q]  <= lg_b;
          if (last_idx) begin
            state_q <= S_FIN;
          end else begin
            idx_q   <= idx_q + BTN_W'(1);
            state_q <= S_RD;
          end
        end
        S_CLR: begin
          short_q <= '0;
          long_q  <= '0;
          if (last_idx) begin
            state_q <= S_FIN;
          end else begin
            idx_q <= idx_q + BTN_W'(1);
          end
        end
        S_FIN: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o        = (state_q == S_IDLE);
  assign res_valid_o       = (state_q == S_FIN);
  assign res_o.short_flags = short_q;
  assign res_o.long_flags  = long_q;

endmodule

### hw/rtl/button_press_classifier.sv
// Top level of the button press classifier: APB register file, item
// sequencer and output word register. Depends on bpc_pkg, bpc_seq.
//
// Debounces the buttons and reports short and long press events, one output
// word per input word. Per-button state lives in a small RAM that is read,
// updated and written back one button at a time: a poll reads each button
// and updates it in two steps before hand-off, an edge word reads and writes
// one button, a clear writes every button and an unused op goes to hand-off.
// A finished word waits in the output register while the next input word is
// taken. Reset leaves all button state at zero at once.
module button_press_classifier (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bpc_pkg::APB_AW-1:0]  paddr,
  input  logic [bpc_pkg::APB_DW-1:0]  pwdata,
  output logic [bpc_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [bpc_pkg::OP_W-1:0]    op_i,
  input  logic [bpc_pkg::TIME_W-1:0]  now_ms_i,
  input  logic [bpc_pkg::RAW_W-1:0]   raw_pressed_i,
  input  logic [bpc_pkg::EDGE_W-1:0]  edge_button_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bpc_pkg::EVT_W-1:0]   short_events_o,
  output logic [bpc_pkg::EVT_W-1:0]   long_events_o,
  output logic                        any_event_o
);
  import bpc_pkg::*;

  cfg_t             cfg_q;
  logic             wr_en;
  logic             res_valid;
  logic             res_ready;
  res_t             res;
  logic             out_valid_q;
  logic [EVT_W-1:0] short_q;
  logic [EVT_W-1:0] long_q;
  logic             any_q;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_time   <= DEBOUNCE_RST;
      cfg_q.long_press_time <= LONG_RST;
    end else if (wr_en) begin
      if (paddr[2] == ADDR_DEBOUNCE[2]) begin
        cfg_q.debounce_time <= pwdata[CFG_W-1:0];
      end else begin
        cfg_q.long_press_time <= pwdata[CFG_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr)
      ADDR_DEBOUNCE: prdata = APB_DW'(cfg_q.debounce_time);
      ADDR_LONG:     prdata = APB_DW'(cfg_q.long_press_time);
      default:       prdata = '0;
    endcase
  end

  bpc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .now_i      (now_ms_i),
    .raw_i      (raw_pressed_i),
    .btn_i      (edge_button_i),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      short_q     <= '0;
      long_q      <= '0;
      any_q       <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
      if (res_valid) begin
        short_q <= EVT_W'(res.short_flags);
        long_q  <= EVT_W'(res.long_flags);
        any_q   <= (res.short_flags != '0) || (res.long_flags != '0);
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign short_events_o = short_q;
  assign long_events_o  = long_q;
  assign any_event_o    = any_q;

endmodule
